### src/bni_pkg.sv
// Shared types and constants of the batch normalisation block.
// Used by bni_ctrl, bni_dp and batch_norm_inference; depends on nothing.
`default_nettype none

package bni_pkg;

    localparam int unsigned DEF_MAX_CHANNELS = 64;
    localparam int unsigned DEF_MAX_SPATIAL  = 16777216;

    localparam int CHANNEL_W   = 6;
    localparam int DATA_W      = 32;
    localparam int VAR_W       = 31;
    localparam int EPS_W       = 16;
    localparam int COUNT_W     = 7;
    localparam int SPATIAL_W   = 25;
    localparam int LIM_W       = 32;
    localparam int S_TDATA_W   = 168;
    localparam int M_TDATA_W   = 40;
    localparam int M_TUSER_W   = 2;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 32;
    localparam int TBL_W       = 3 * DATA_W + VAR_W;

    localparam logic [CFG_INDEX_W-1:0] CFG_EPSILON  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_CHANNELS = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_SPATIAL  = 2'd2;

    localparam logic [EPS_W-1:0]     EPS_RESET     = 16'd1;
    localparam logic [COUNT_W-1:0]   COUNT_RESET   = 7'd1;
    localparam logic [SPATIAL_W-1:0] SPATIAL_RESET = 25'd1;

    localparam logic KIND_LOAD   = 1'b0;
    localparam logic KIND_SAMPLE = 1'b1;

    localparam int ROOT_W    = 24;
    localparam int RAD_W     = 48;
    localparam int SQREM_W   = 25;
    localparam int HALF_W    = 16;
    localparam int PROD_W    = 48;
    localparam int ACC_W     = 64;
    localparam int QUO_W     = 34;
    localparam int SUM_W     = 36;
    localparam int DIV_BITS  = 2;

    localparam int SQRT_STEPS = 24;
    localparam int DIV_STEPS  = 17;
    localparam int STEP_W     = 5;

    localparam logic [STEP_W-1:0] MUL_STEP_HI  = 5'd1;
    localparam logic [STEP_W-1:0] MUL_STEP_ADD = 5'd2;

    localparam logic [DATA_W-1:0] DATA_MAX = 32'h7FFF_FFFF;
    localparam logic [DATA_W-1:0] DATA_MIN = 32'h8000_0000;

    typedef struct packed {
        logic take_load;
        logic take_sample;
        logic latch;
        logic sqrt_step;
        logic mul_hi;
        logic acc_load;
        logic acc_add;
        logic div_prep;
        logic div_step;
        logic out_load;
    } bni_cmd_t;

    typedef struct packed {
        logic zero_den;
        logic out_free;
    } bni_status_t;

endpackage

`default_nettype wire

### src/bni_ctrl.sv
// Sequencer of the batch normalisation block: accepts words and steps the datapath.
// Depends on bni_pkg for the command and status structs.
`default_nettype none

module bni_ctrl (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_tvalid,
    input  wire logic                  in_kind,
    output logic                       s_tready,
    input  wire bni_pkg::bni_status_t  status,
    output bni_pkg::bni_cmd_t          cmd
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_READ = 3'd1;
    localparam logic [2:0] ST_SQRT = 3'd2;
    localparam logic [2:0] ST_PREP = 3'd3;
    localparam logic [2:0] ST_DIV  = 3'd4;
    localparam logic [2:0] ST_FIN  = 3'd5;

    logic [2:0]                   state_reg, state_next;
    logic [bni_pkg::STEP_W-1:0]   step_reg, step_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        step_next  = step_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    if (in_kind == bni_pkg::KIND_SAMPLE) begin
                        cmd.take_sample = 1'b1;
                        state_next      = ST_READ;
                    end else begin
                        cmd.take_load = 1'b1;
                    end
                end
            end
            ST_READ: begin
                cmd.latch  = 1'b1;
                step_next  = '0;
                state_next = ST_SQRT;
            end
            ST_SQRT: begin
                if (status.zero_den) begin
                    state_next = ST_FIN;
                end else begin
                    cmd.sqrt_step = 1'b1;
                    cmd.mul_hi    = (step_reg == bni_pkg::MUL_STEP_HI);
                    cmd.acc_load  = (step_reg == bni_pkg::MUL_STEP_HI);
                    cmd.acc_add   = (step_reg == bni_pkg::MUL_STEP_ADD);
                    if (step_reg == bni_pkg::STEP_W'(bni_pkg::SQRT_STEPS - 1)) begin
                        step_next  = '0;
                        state_next = ST_PREP;
                    end else begin
                        step_next = step_reg + 1'b1;
                    end
                end
            end
            ST_PREP: begin
                cmd.div_prep = 1'b1;
                step_next    = '0;
                state_next   = ST_DIV;
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                if (step_reg == bni_pkg::STEP_W'(bni_pkg::DIV_STEPS - 1)) begin
                    step_next  = '0;
                    state_next = ST_FIN;
                end else begin
                    step_next = step_reg + 1'b1;
                end
            end
            ST_FIN: begin
                if (status.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

### src/bni_dp.sv
// Datapath of the batch normalisation block: registers, parameter tables, position
// counters, square root, multiplier, divider and output register. Depends on bni_pkg.
`default_nettype none

module bni_dp #(
    parameter int unsigned MAX_CHANNELS = bni_pkg::DEF_MAX_CHANNELS,
    parameter int unsigned MAX_SPATIAL  = bni_pkg::DEF_MAX_SPATIAL
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire bni_pkg::bni_cmd_t                 cmd,
    output bni_pkg::bni_status_t                   status,
    input  wire logic [bni_pkg::S_TDATA_W-1:0]     s_tdata,
    input  wire logic                              s_tlast,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [bni_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  wire logic [bni_pkg::CFG_DATA_W-1:0]    cfg_data,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic [bni_pkg::M_TDATA_W-1:0]          m_tdata,
    output logic [bni_pkg::M_TUSER_W-1:0]          m_tuser,
    output logic                                   m_tlast
);

    localparam int CH_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int PL_W = (MAX_SPATIAL > 1) ? $clog2(MAX_SPATIAL) : 1;
    localparam int LW   = bni_pkg::LIM_W;

    // Input word fields.
    logic [bni_pkg::CHANNEL_W-1:0] in_channel;
    logic [bni_pkg::DATA_W-1:0]    in_mean, in_scale, in_bias, in_sample;
    logic [bni_pkg::VAR_W-1:0]     in_var;

    assign in_channel = s_tdata[5:0];
    assign in_mean    = s_tdata[37:6];
    assign in_var     = s_tdata[68:38];
    assign in_scale   = s_tdata[100:69];
    assign in_bias    = s_tdata[132:101];
    assign in_sample  = s_tdata[164:133];

    // Configuration registers.
    logic [bni_pkg::EPS_W-1:0]     eps_reg;
    logic [bni_pkg::COUNT_W-1:0]   count_reg;
    logic [bni_pkg::SPATIAL_W-1:0] spatial_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            eps_reg     <= bni_pkg::EPS_RESET;
            count_reg   <= bni_pkg::COUNT_RESET;
            spatial_reg <= bni_pkg::SPATIAL_RESET;
        end else if (cfg_valid) begin
            case (cfg_index)
                bni_pkg::CFG_EPSILON:  eps_reg     <= cfg_data[bni_pkg::EPS_W-1:0];
                bni_pkg::CFG_CHANNELS: count_reg   <= cfg_data[bni_pkg::COUNT_W-1:0];
                bni_pkg::CFG_SPATIAL:  spatial_reg <= cfg_data[bni_pkg::SPATIAL_W-1:0];
                default: ;
            endcase
        end
    end

    // Effective limits and position counters.
    logic [LW-1:0]   nch_raw, nsp_raw, nch, nsp, c_inc, p_inc;
    logic [CH_W-1:0] chpos_reg, c_eff;
    logic [PL_W-1:0] plane_reg, p_eff;

    assign nch_raw = (count_reg == '0) ? LW'(1) : LW'(count_reg);
    assign nsp_raw = (spatial_reg == '0) ? LW'(1) : LW'(spatial_reg);
    assign nch     = (nch_raw > LW'(MAX_CHANNELS)) ? LW'(MAX_CHANNELS) : nch_raw;
    assign nsp     = (nsp_raw > LW'(MAX_SPATIAL)) ? LW'(MAX_SPATIAL) : nsp_raw;
    assign c_eff   = (LW'(chpos_reg) >= nch) ? '0 : chpos_reg;
    assign p_eff   = (LW'(plane_reg) >= nsp) ? '0 : plane_reg;
    assign c_inc   = LW'(c_eff) + LW'(1);
    assign p_inc   = LW'(p_eff) + LW'(1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            chpos_reg <= '0;
            plane_reg <= '0;
        end else if (cmd.take_sample) begin
            if (s_tlast) begin
                chpos_reg <= '0;
                plane_reg <= '0;
            end else if (p_inc >= nsp) begin
                plane_reg <= '0;
                chpos_reg <= (c_inc >= nch) ? '0 : CH_W'(c_inc);
            end else begin
                plane_reg <= PL_W'(p_inc);
                chpos_reg <= c_eff;
            end
        end
    end

    // Parameter table: bias, scale, variance and mean of one channel per row.
    logic [bni_pkg::TBL_W-1:0]  tbl_mem [MAX_CHANNELS];
    logic [bni_pkg::TBL_W-1:0]  tbl_rd_reg;
    logic                       load_ok;
    logic [bni_pkg::DATA_W-1:0] sample_reg;
    logic [CH_W-1:0]            cur_ch_reg;
    logic                       cur_last_reg;

    assign load_ok = (LW'(in_channel) < LW'(MAX_CHANNELS));

    always_ff @(posedge aclk) begin
        if (cmd.take_load && load_ok) begin
            tbl_mem[CH_W'(in_channel)] <= {in_bias, in_scale, in_var, in_mean};
        end
        if (cmd.take_sample) begin
            tbl_rd_reg   <= tbl_mem[c_eff];
            sample_reg   <= in_sample;
            cur_ch_reg   <= c_eff;
            cur_last_reg <= s_tlast;
        end
    end

    logic [bni_pkg::DATA_W-1:0] rd_mean, rd_scale, rd_bias;
    logic [bni_pkg::VAR_W-1:0]  rd_var;

    assign rd_mean  = tbl_rd_reg[31:0];
    assign rd_var   = tbl_rd_reg[62:32];
    assign rd_scale = tbl_rd_reg[94:63];
    assign rd_bias  = tbl_rd_reg[126:95];

    // Operand preparation.
    logic [bni_pkg::DATA_W-1:0]   v_sum, mag_d, mag_s;
    logic [bni_pkg::DATA_W:0]     diff;
    logic [bni_pkg::DATA_W-1:0]   magd_reg, mags_reg;
    logic                         neg_reg, zero_reg;

    assign v_sum = {1'b0, rd_var} + bni_pkg::DATA_W'(eps_reg);
    assign diff  = {sample_reg[31], sample_reg} - {rd_mean[31], rd_mean};
    assign mag_d = diff[32] ? bni_pkg::DATA_W'(-diff) : diff[31:0];
    assign mag_s = rd_scale[31] ? (~rd_scale + 1'b1) : rd_scale;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            zero_reg <= 1'b0;
        end else if (cmd.latch) begin
            zero_reg <= (v_sum == '0);
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.latch) begin
            magd_reg <= mag_d;
            mags_reg <= mag_s;
            neg_reg  <= diff[32] ^ rd_scale[31];
        end
    end

    // Square root, one root bit per step.
    logic [bni_pkg::RAD_W-1:0]   rad_reg;
    logic [bni_pkg::SQREM_W-1:0] sq_rem_reg;
    logic [bni_pkg::ROOT_W-1:0]  root_reg;
    logic [bni_pkg::SQREM_W+1:0] sq_r, sq_t;

    assign sq_r = {sq_rem_reg, rad_reg[bni_pkg::RAD_W-1 -: 2]};
    assign sq_t = {1'b0, root_reg, 2'b01};

    always_ff @(posedge aclk) begin
        if (cmd.latch) begin
            rad_reg    <= {v_sum, 16'h0000};
            sq_rem_reg <= '0;
            root_reg   <= '0;
        end else if (cmd.sqrt_step) begin
            rad_reg <= {rad_reg[bni_pkg::RAD_W-3:0], 2'b00};
            if (sq_r >= sq_t) begin
                sq_rem_reg <= bni_pkg::SQREM_W'(sq_r - sq_t);
                root_reg   <= {root_reg[bni_pkg::ROOT_W-2:0], 1'b1};
            end else begin
                sq_rem_reg <= bni_pkg::SQREM_W'(sq_r);
                root_reg   <= {root_reg[bni_pkg::ROOT_W-2:0], 1'b0};
            end
        end
    end

    // Product of the magnitudes from two 16 by 32 bit partial products.
    logic [bni_pkg::HALF_W-1:0] mul_op;
    logic [bni_pkg::PROD_W-1:0] prod_reg;
    logic [bni_pkg::ACC_W-1:0]  acc_reg;

    assign mul_op = cmd.mul_hi ? magd_reg[31:16] : magd_reg[15:0];

    always_ff @(posedge aclk) begin
        prod_reg <= bni_pkg::PROD_W'(mul_op) * bni_pkg::PROD_W'(mags_reg);
        if (cmd.acc_load) begin
            acc_reg <= bni_pkg::ACC_W'(prod_reg);
        end else if (cmd.acc_add) begin
            acc_reg <= acc_reg + bni_pkg::ACC_W'({prod_reg, 16'h0000});
        end
    end

    // Division of the product by the root, two quotient bits per step.
    logic [bni_pkg::ROOT_W-1:0] div_rem_reg, rem_a;
    logic [bni_pkg::QUO_W-1:0]  div_dvd_reg, dvd_a, quo_reg, quo_a;
    logic [bni_pkg::ROOT_W:0]   div_trial;
    logic                       ovf_reg;

    always_comb begin
        rem_a     = div_rem_reg;
        dvd_a     = div_dvd_reg;
        quo_a     = quo_reg;
        div_trial = '0;
        for (int i = 0; i < bni_pkg::DIV_BITS; i++) begin
            div_trial = {rem_a, dvd_a[bni_pkg::QUO_W-1]};
            dvd_a     = {dvd_a[bni_pkg::QUO_W-2:0], 1'b0};
            if (div_trial >= {1'b0, root_reg}) begin
                rem_a = bni_pkg::ROOT_W'(div_trial - {1'b0, root_reg});
                quo_a = {quo_a[bni_pkg::QUO_W-2:0], 1'b1};
            end else begin
                rem_a = div_trial[bni_pkg::ROOT_W-1:0];
                quo_a = {quo_a[bni_pkg::QUO_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.div_prep) begin
            ovf_reg     <= (acc_reg[63:34] >= {6'b000000, root_reg});
            div_rem_reg <= acc_reg[57:34];
            div_dvd_reg <= acc_reg[33:0];
            quo_reg     <= '0;
        end else if (cmd.div_step) begin
            div_rem_reg <= rem_a;
            div_dvd_reg <= dvd_a;
            quo_reg     <= quo_a;
        end
    end

    // Sign, bias and saturation.
    logic signed [bni_pkg::SUM_W-1:0] q_signed, sum;
    logic [bni_pkg::DATA_W-1:0]       res;
    logic                             sat;

    assign q_signed = neg_reg ? -$signed({2'b00, quo_reg}) : $signed({2'b00, quo_reg});
    assign sum      = q_signed + $signed({{4{rd_bias[31]}}, rd_bias});

    always_comb begin
        res = sum[bni_pkg::DATA_W-1:0];
        sat = 1'b0;
        if (zero_reg) begin
            res = '0;
        end else if (ovf_reg) begin
            res = neg_reg ? bni_pkg::DATA_MIN : bni_pkg::DATA_MAX;
            sat = 1'b1;
        end else if ((sum[35:31] != 5'b00000) && (sum[35:31] != 5'b11111)) begin
            res = sum[35] ? bni_pkg::DATA_MIN : bni_pkg::DATA_MAX;
            sat = 1'b1;
        end
    end

    // Output register.
    logic                            m_tvalid_reg;
    logic [bni_pkg::M_TDATA_W-1:0]   m_tdata_reg;
    logic [bni_pkg::M_TUSER_W-1:0]   m_tuser_reg;
    logic                            m_tlast_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_tdata_reg <= {2'b00, bni_pkg::CHANNEL_W'(cur_ch_reg), res};
            m_tuser_reg <= {zero_reg, sat};
            m_tlast_reg <= cur_last_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

    assign status.zero_den = zero_reg;
    assign status.out_free = !m_tvalid_reg || m_tready;

endmodule

`default_nettype wire

### src/batch_norm_inference.sv
// Top level of the batch normalisation block for inference, Q16.16 fixed point.
// Instantiates bni_ctrl and bni_dp; depends on bni_pkg.
//
// A load word writes one channel's mean, variance, scale and bias and gives no
// result. A sample word is normalised with the parameters of the channel that the
// position counters point at, and passes through a table read, an operand latch, a
// square root (one root bit per step), a divider set-up, a division (two quotient
// bits per step) and a load into the output register before the next word is
// accepted. A sample whose variance plus epsilon is zero skips the square root, the
// divider set-up and the division. The load into the output register waits for as
// long as the previous result is still held there unaccepted. A finished result
// waits in the output register while the next word is taken. There is no clearing
// pass after reset; a channel must be loaded before a sample uses it.
`default_nettype none

module batch_norm_inference #(
    parameter int unsigned MAX_CHANNELS = bni_pkg::DEF_MAX_CHANNELS,
    parameter int unsigned MAX_SPATIAL  = bni_pkg::DEF_MAX_SPATIAL
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // channel, mean_value, variance_value, scale_value, bias_value, sample, zero pad
    input  wire logic [bni_pkg::S_TDATA_W-1:0]     s_tdata,
    // kind
    input  wire logic                              s_tuser,
    input  wire logic                              s_tlast,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // result, result_channel, zero pad
    output logic [bni_pkg::M_TDATA_W-1:0]          m_tdata,
    // saturated, zero_denominator
    output logic [bni_pkg::M_TUSER_W-1:0]          m_tuser,
    output logic                                   m_tlast,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [bni_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  wire logic [bni_pkg::CFG_DATA_W-1:0]    cfg_data
);

    bni_pkg::bni_cmd_t    cmd;
    bni_pkg::bni_status_t status;

    bni_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .in_kind  (s_tuser),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    bni_dp #(
        .MAX_CHANNELS (MAX_CHANNELS),
        .MAX_SPATIAL  (MAX_SPATIAL)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .status    (status),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    a_sample_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && (s_tuser == bni_pkg::KIND_SAMPLE)) |=> !s_tready)
        else $error("input taken again while a sample is in progress");

    a_load_single: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && (s_tuser == bni_pkg::KIND_LOAD)) |=> s_tready)
        else $error("a load word held the block busy");

    a_flags_apart: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
        else $error("saturation and zero denominator flagged together");

    a_zero_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[1]) |-> (m_tdata[31:0] == '0))
        else $error("zero denominator with a non-zero result");

endmodule

`default_nettype wire

### verif/tb_batch_norm_inference.sv
// Self-checking testbench for batch_norm_inference: loads, samples and register writes
// are checked against a Q16.16 predictor kept in a small scoreboard class.
// Depends on bni_pkg and batch_norm_inference.

module tb_batch_norm_inference;

    localparam int CLK_HALF     = 4;
    localparam int CYCLE_LIMIT  = 600000;
    localparam int DRAIN_CYCLES = 60;
    localparam int HOLD_CYCLES  = 600;
    localparam int PHASE_WORDS  = 20;
    localparam int TENSOR_CAP   = 72;
    localparam int NUM_SLOTS    = 5;
    localparam int PRINT_CAP    = 100;

    localparam logic [bni_pkg::CFG_INDEX_W-1:0] CFG_SPARE = 2'd3;

    localparam longint SAT_HI = 64'sd2147483647;
    localparam longint SAT_LO = -64'sd2147483648;

    typedef struct {
        logic                               kind;
        bit [bni_pkg::CHANNEL_W-1:0]        channel;
        bit signed [bni_pkg::DATA_W-1:0]    mean;
        bit [bni_pkg::VAR_W-1:0]            variance;
        bit signed [bni_pkg::DATA_W-1:0]    scale;
        bit signed [bni_pkg::DATA_W-1:0]    bias;
        bit signed [bni_pkg::DATA_W-1:0]    sample;
        bit                                 last;
    } bn_word_t;

    typedef struct {
        logic [bni_pkg::DATA_W-1:0]         value;
        logic [bni_pkg::CHANNEL_W-1:0]      channel;
        logic                               saturated;
        logic                               zero_den;
        logic                               last;
    } norm_result_t;

    class norm_scoreboard;
        bit signed [bni_pkg::DATA_W-1:0]    mean_tbl[64];
        bit [bni_pkg::VAR_W-1:0]            var_tbl[64];
        bit signed [bni_pkg::DATA_W-1:0]    scale_tbl[64];
        bit signed [bni_pkg::DATA_W-1:0]    bias_tbl[64];
        bit                                 loaded[64];
        int unsigned                        plane_pos;
        int unsigned                        chan_pos;
        bit [bni_pkg::EPS_W-1:0]            eps_reg     = bni_pkg::EPS_RESET;
        bit [bni_pkg::COUNT_W-1:0]          count_reg   = bni_pkg::COUNT_RESET;
        bit [bni_pkg::SPATIAL_W-1:0]        spatial_reg = bni_pkg::SPATIAL_RESET;
        norm_result_t                       expected_q[$];
        int errors, printed, loads, checked, sat_seen, zero_seen, writes;

        task report_mismatch(string msg);
            errors++;
            if (printed < PRINT_CAP) begin
                printed++;
                $display("mismatch: %s", msg);
            end
        endtask

        function void write_register(logic [bni_pkg::CFG_INDEX_W-1:0] idx,
                                     logic [bni_pkg::CFG_DATA_W-1:0] data);
            writes++;
            case (idx)
                bni_pkg::CFG_EPSILON:  eps_reg     = data[bni_pkg::EPS_W-1:0];
                bni_pkg::CFG_CHANNELS: count_reg   = data[bni_pkg::COUNT_W-1:0];
                bni_pkg::CFG_SPATIAL:  spatial_reg = data[bni_pkg::SPATIAL_W-1:0];
                default: ;
            endcase
        endfunction

        function int unsigned active_channels();
            int unsigned c;
            c = count_reg;
            if (c == 0) c = 1;
            if (c > bni_pkg::DEF_MAX_CHANNELS) c = bni_pkg::DEF_MAX_CHANNELS;
            return c;
        endfunction

        function int unsigned plane_length();
            int unsigned s;
            s = spatial_reg;
            if (s == 0) s = 1;
            if (s > bni_pkg::DEF_MAX_SPATIAL) s = bni_pkg::DEF_MAX_SPATIAL;
            return s;
        endfunction

        function int unsigned next_channel();
            return (chan_pos >= active_channels()) ? 0 : chan_pos;
        endfunction

        function longint unsigned root_of(longint unsigned x);
            longint unsigned r, t;
            r = 0;
            for (int b = 23; b >= 0; b--) begin
                t = r | (64'd1 << b);
                if (t * t <= x) r = t;
            end
            return r;
        endfunction

        function norm_result_t normalise(int unsigned c, bit signed [bni_pkg::DATA_W-1:0] x);
            norm_result_t r;
            longint unsigned v, d, mag_d, mag_s, q;
            longint diff, gain, acc;
            bit neg;
            r.value     = '0;
            r.channel   = c;
            r.saturated = 1'b0;
            r.zero_den  = 1'b0;
            r.last      = 1'b0;
            v = longint'(var_tbl[c]) + longint'(eps_reg);
            if (v == 0) begin
                r.zero_den = 1'b1;
                return r;
            end
            diff  = longint'(x) - longint'(mean_tbl[c]);
            gain  = longint'(scale_tbl[c]);
            mag_d = (diff < 0) ? -diff : diff;
            mag_s = (gain < 0) ? -gain : gain;
            neg   = (diff < 0) != (gain < 0);
            d     = root_of(v << 16);
            q     = (mag_d * mag_s) / d;
            acc   = neg ? -longint'(q) : longint'(q);
            acc   = acc + longint'(bias_tbl[c]);
            if (acc > SAT_HI) begin
                acc = SAT_HI;
                r.saturated = 1'b1;
            end else if (acc < SAT_LO) begin
                acc = SAT_LO;
                r.saturated = 1'b1;
            end
            r.value = acc[31:0];
            return r;
        endfunction

        function void note_word(bn_word_t w);
            int unsigned nch, nsp, c;
            norm_result_t r;
            if (w.kind == bni_pkg::KIND_LOAD) begin
                mean_tbl[w.channel]  = w.mean;
                var_tbl[w.channel]   = w.variance;
                scale_tbl[w.channel] = w.scale;
                bias_tbl[w.channel]  = w.bias;
                loaded[w.channel]    = 1'b1;
                loads++;
                return;
            end
            nch = active_channels();
            nsp = plane_length();
            if (chan_pos >= nch) chan_pos = 0;
            if (plane_pos >= nsp) plane_pos = 0;
            c = chan_pos;
            r = normalise(c, w.sample);
            r.last = w.last;
            expected_q.push_back(r);
            if (w.last) begin
                plane_pos = 0;
                chan_pos  = 0;
            end else begin
                plane_pos++;
                if (plane_pos >= nsp) begin
                    plane_pos = 0;
                    chan_pos++;
                    if (chan_pos >= nch) chan_pos = 0;
                end
            end
        endfunction

        task check_word(norm_result_t got);
            norm_result_t want;
            if (expected_q.size() == 0) begin
                report_mismatch($sformatf("result word %h with nothing outstanding", got.value));
                return;
            end
            want = expected_q.pop_front();
            checked++;
            if (want.saturated) sat_seen++;
            if (want.zero_den) zero_seen++;
            if (got.value !== want.value)
                report_mismatch($sformatf("word %0d: result %h, predicted %h",
                                          checked, got.value, want.value));
            if (got.channel !== want.channel)
                report_mismatch($sformatf("word %0d: channel %0d, predicted %0d",
                                          checked, got.channel, want.channel));
            if (got.saturated !== want.saturated)
                report_mismatch($sformatf("word %0d: saturated %b, predicted %b",
                                          checked, got.saturated, want.saturated));
            if (got.zero_den !== want.zero_den)
                report_mismatch($sformatf("word %0d: zero denominator %b, predicted %b",
                                          checked, got.zero_den, want.zero_den));
            if (got.last !== want.last)
                report_mismatch($sformatf("word %0d: last %b, predicted %b",
                                          checked, got.last, want.last));
        endtask
    endclass

    logic                                aclk = 1'b0;
    logic                                aresetn;
    logic                                s_tvalid;
    logic                                s_tready;
    logic [bni_pkg::S_TDATA_W-1:0]       s_tdata;
    logic                                s_tuser;
    logic                                s_tlast;
    logic                                m_tvalid;
    logic                                m_tready;
    logic [bni_pkg::M_TDATA_W-1:0]       m_tdata;
    logic [bni_pkg::M_TUSER_W-1:0]       m_tuser;
    logic                                m_tlast;
    logic                                cfg_valid;
    logic                                cfg_ready;
    logic [bni_pkg::CFG_INDEX_W-1:0]     cfg_index;
    logic [bni_pkg::CFG_DATA_W-1:0]      cfg_data;

    norm_scoreboard sb;
    norm_result_t   seen;
    int             cycle_count = 0;
    int             word_count = 0;
    int             tx_idle_pct = 0;
    int             rx_idle_pct = 0;
    int             rx_hold_cycles = 0;

    batch_norm_inference i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #CLK_HALF aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
    end

    // The long hold-off is counted down here, so the sender keeps offering words meanwhile.
    initial begin
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (rx_hold_cycles > 0) begin
                m_tready <= 1'b0;
                rx_hold_cycles--;
            end else begin
                m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            seen.value     = m_tdata[31:0];
            seen.channel   = m_tdata[37:32];
            seen.saturated = m_tuser[0];
            seen.zero_den  = m_tuser[1];
            seen.last      = m_tlast;
            sb.check_word(seen);
        end
    end

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("timeout after %0d cycles with %0d results outstanding",
                 cycle_count, sb.expected_q.size());
        $display("status: fail");
        $finish;
    end

    function automatic bn_word_t random_load(bit [bni_pkg::CHANNEL_W-1:0] ch);
        bn_word_t w;
        w.kind    = bni_pkg::KIND_LOAD;
        w.channel = ch;
        w.mean    = $urandom;
        case ($urandom_range(0, 9))
            0:       w.variance = '0;
            1, 2:    w.variance = $urandom_range(0, 32'hFFFF);
            3, 4, 5, 6, 7: w.variance = $urandom_range(32'h1_0000, 32'h100_0000);
            default: w.variance = $urandom;
        endcase
        if ($urandom_range(0, 1))
            w.scale = int'($urandom_range(0, 32'h8_0000)) - 32'sh4_0000;
        else
            w.scale = $urandom;
        if ($urandom_range(0, 1))
            w.bias = int'($urandom_range(0, 32'h8_0000)) - 32'sh4_0000;
        else
            w.bias = $urandom;
        w.sample = $urandom;
        w.last   = ($urandom_range(0, 3) == 0);
        return w;
    endfunction

    function automatic bn_word_t make_load(bit [5:0] ch, bit [31:0] mean, bit [30:0] variance,
                                           bit [31:0] scale, bit [31:0] bias, bit last);
        bn_word_t w;
        w          = random_load(ch);
        w.mean     = mean;
        w.variance = variance;
        w.scale    = scale;
        w.bias     = bias;
        w.last     = last;
        return w;
    endfunction

    task automatic send_word(bn_word_t w);
        while (rx_hold_cycles == 0 && $urandom_range(0, 99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= w.kind;
        s_tlast  <= w.last;
        s_tdata  <= {3'b000, w.sample, w.bias, w.scale, w.variance, w.mean, w.channel};
        do @(posedge aclk); while (!s_tready);
        sb.note_word(w);
        word_count++;
    endtask

    task automatic stop_sending();
        s_tvalid <= 1'b0;
    endtask

    // A sample never reaches a channel whose parameters were not loaded yet.
    task automatic send_sample(bit last, bit fixed, bit [31:0] x);
        bn_word_t w;
        int unsigned ch;
        ch = sb.next_channel();
        if (!sb.loaded[ch]) send_word(random_load(ch));
        w = random_load($urandom);
        w.kind = bni_pkg::KIND_SAMPLE;
        w.last = last;
        if (fixed)
            w.sample = x;
        else if ($urandom_range(0, 1))
            w.sample = sb.mean_tbl[ch] + (int'($urandom_range(0, 32'h8_0000)) - 32'sh4_0000);
        else
            w.sample = $urandom;
        send_word(w);
    endtask

    task automatic send_tensor();
        int unsigned nch, total;
        nch   = sb.active_channels();
        total = nch * sb.plane_length();
        if (total > TENSOR_CAP) total = $urandom_range(4, TENSOR_CAP);
        for (int unsigned ch = 0; ch < nch; ch++)
            if ($urandom_range(0, 1)) send_word(random_load(ch));
        for (int unsigned i = 0; i < total; i++)
            send_sample(i == total - 1, 1'b0, '0);
    endtask

    task automatic send_noise();
        int n;
        n = $urandom_range(1, 6);
        repeat (n) begin
            if ($urandom_range(0, 1))
                send_word(random_load($urandom));
            else
                send_sample($urandom_range(0, 9) == 0, 1'b0, '0);
        end
    endtask

    task automatic wait_drained();
        do @(posedge aclk); while (sb.expected_q.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_register(logic [bni_pkg::CFG_INDEX_W-1:0] idx,
                                  logic [bni_pkg::CFG_DATA_W-1:0] data);
        cfg_index <= idx;
        cfg_data  <= data;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        sb.write_register(idx, data);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic apply_settings(int slot);
        bit [31:0]                      junk;
        bit [bni_pkg::EPS_W-1:0]        eps;
        bit [bni_pkg::COUNT_W-1:0]      cnt;
        bit [bni_pkg::SPATIAL_W-1:0]    plane;
        junk = $urandom;
        case ($urandom_range(0, 3))
            0:       eps = '0;
            1:       eps = '1;
            default: eps = $urandom;
        endcase
        if (slot == 1) eps = '0;
        case ($urandom_range(0, 7))
            0:       cnt = '0;
            1:       cnt = $urandom_range(65, 127);
            2:       cnt = 7'd64;
            default: cnt = $urandom_range(1, 8);
        endcase
        case ($urandom_range(0, 7))
            0:       plane = '0;
            1:       plane = $urandom_range(1, 16);
            7:       plane = $urandom;
            default: plane = $urandom_range(1, 4);
        endcase
        if (slot == 0) begin
            cnt   = 7'd64;
            plane = 25'd1;
        end else if (slot == 3) begin
            cnt   = 7'd1;
            plane = $urandom_range(4096, 32'h1FF_FFFF);
        end
        write_register(bni_pkg::CFG_EPSILON, {junk[31:16], eps});
        write_register(bni_pkg::CFG_CHANNELS, {junk[31:7], cnt});
        write_register(bni_pkg::CFG_SPATIAL, {junk[31:25], plane});
        if ($urandom_range(0, 3) == 0) write_register(CFG_SPARE, $urandom);
    endtask

    task automatic run_directed();
        send_word(make_load(6'd0, 32'h0, 31'h0, 32'h0001_0000, 32'h0, 1'b1));
        send_sample(1'b0, 1'b1, 32'h0000_0000);
        send_sample(1'b0, 1'b1, 32'h7FFF_FFFF);
        send_sample(1'b1, 1'b1, 32'h8000_0000);
        send_word(make_load(6'd0, 32'h7FFF_FFFF, 31'h7FFF_FFFF, 32'h8000_0000,
                            32'h8000_0000, 1'b0));
        send_sample(1'b0, 1'b1, 32'h8000_0000);
        send_sample(1'b0, 1'b1, 32'h7FFF_FFFF);
        send_word(make_load(6'd0, 32'h8000_0000, 31'h0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0));
        send_sample(1'b0, 1'b1, 32'h7FFF_FFFF);
        send_sample(1'b1, 1'b1, 32'h8000_0000);
        send_word(make_load(6'd63, 32'hFFFF_FFFF, 31'h1, 32'hFFFF_FFFF, 32'h0, 1'b1));
        stop_sending();
        wait_drained();

        // Zero epsilon with a zero variance, and register values of zero for both sizes.
        write_register(bni_pkg::CFG_EPSILON, 32'hFFFF_0000);
        write_register(bni_pkg::CFG_CHANNELS, 32'hFFFF_FF80);
        write_register(bni_pkg::CFG_SPATIAL, 32'hFE00_0000);
        send_word(make_load(6'd0, 32'h0, 31'h0, 32'h0001_0000, 32'h5, 1'b0));
        send_sample(1'b0, 1'b1, 32'h0000_1234);
        send_sample(1'b1, 1'b1, 32'hFFFF_0000);
        stop_sending();
        wait_drained();

        // Oversized channel count, then a mid-tensor change leaves both counters stale.
        write_register(bni_pkg::CFG_EPSILON, 32'h0000_FFFF);
        write_register(bni_pkg::CFG_CHANNELS, 32'h0000_007F);
        write_register(bni_pkg::CFG_SPATIAL, 32'h0000_0002);
        write_register(CFG_SPARE, 32'hFFFF_FFFF);
        repeat (5) send_sample(1'b0, 1'b0, '0);
        stop_sending();
        wait_drained();
        write_register(bni_pkg::CFG_CHANNELS, 32'h0000_0001);
        write_register(bni_pkg::CFG_SPATIAL, 32'h0000_0001);
        send_sample(1'b0, 1'b0, '0);
        send_sample(1'b1, 1'b0, '0);
        stop_sending();
        wait_drained();
        write_register(bni_pkg::CFG_SPATIAL, 32'h01FF_FFFF);
    endtask

    initial begin
        int start;
        sb = new;
        aresetn   <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= 1'b0;
        s_tlast   <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        tx_idle_pct = 38;
        rx_idle_pct = 75;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        run_directed();

        for (int mode = 0; mode < 3; mode++) begin
            case (mode)
                0: begin
                    tx_idle_pct = 38;
                    rx_idle_pct = 75;
                end
                1: begin
                    tx_idle_pct = 75;
                    rx_idle_pct = 38;
                end
                default: begin
                    tx_idle_pct = 0;
                    rx_idle_pct = 0;
                end
            endcase
            for (int slot = 0; slot < NUM_SLOTS; slot++) begin
                stop_sending();
                wait_drained();
                apply_settings(slot);
                if (mode == 2 && slot == 0) rx_hold_cycles = HOLD_CYCLES;
                start = word_count;
                while (word_count - start < PHASE_WORDS) begin
                    if ($urandom_range(0, 4) != 0)
                        send_tensor();
                    else
                        send_noise();
                end
            end
        end
        stop_sending();
        wait_drained();

        $display("covered %0d loads, %0d checked results and %0d register writes",
                 sb.loads, sb.checked, sb.writes);
        $display("%0d saturated and %0d zero-denominator results in %0d cycles",
                 sb.sat_seen, sb.zero_seen, cycle_count);
        if (sb.errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
